FILE: design/prs_pkg.sv
// shared types and constants for the polyline resampler
// no dependencies
package prs_pkg;

  localparam int MaxSegments = 32;
  localparam int CntW = $clog2(MaxSegments + 1);
  localparam int NsW = 16 + CntW;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic               do_seg;
    logic               do_wrap;
    logic               last;
  } prs_cmd_t;

endpackage

FILE: design/prs_front.sv
// front end: accepts vertices, tracks path state and classifies each vertex
// depends on prs_pkg
module prs_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [15:0]  point_x_i,
  input  logic signed [15:0]  point_y_i,
  input  logic                path_first_i,
  input  logic                path_last_i,
  input  logic                path_closed_i,
  input  logic [15:0]         spacing_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output prs_pkg::prs_cmd_t   cmd_o
);
  import prs_pkg::*;

  logic signed [15:0] prev_x_q, prev_y_q, start_x_q, start_y_q;
  logic               in_path_q;
  logic               is_first;
  logic               accept;

  assign is_first    = path_first_i || !in_path_q;
  assign cmd_valid_o = in_valid_i;
  assign in_ready_o  = cmd_ready_i;
  assign accept      = in_valid_i && cmd_ready_i;

  always_comb begin
    cmd_o.x       = point_x_i;
    cmd_o.y       = point_y_i;
    cmd_o.px      = prev_x_q;
    cmd_o.py      = prev_y_q;
    cmd_o.sx      = is_first ? point_x_i : start_x_q;
    cmd_o.sy      = is_first ? point_y_i : start_y_q;
    cmd_o.do_seg  = !is_first && (spacing_i != 16'd0);
    cmd_o.do_wrap = path_last_i && path_closed_i && (spacing_i != 16'd0);
    cmd_o.last    = path_last_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q  <= '0;
      prev_y_q  <= '0;
      start_x_q <= '0;
      start_y_q <= '0;
      in_path_q <= 1'b0;
    end else if (accept) begin
      prev_x_q  <= point_x_i;
      prev_y_q  <= point_y_i;
      in_path_q <= !path_last_i;
      if (is_first) begin
        start_x_q <= point_x_i;
        start_y_q <= point_y_i;
      end
    end
  end

endmodule

FILE: design/prs_queue.sv
// two-entry queue of classified vertices between front and back end
// depends on prs_pkg
module prs_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  prs_pkg::prs_cmd_t wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output prs_pkg::prs_cmd_t rd_data_o
);
  import prs_pkg::*;

  prs_cmd_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      if (push && !pop) count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

endmodule

FILE: design/prs_back.sv
// back end: segment count search, per-segment divide and point stepping
// depends on prs_pkg
module prs_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  prs_pkg::prs_cmd_t  cmd_i,
  input  logic [15:0]        spacing_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  output logic               path_end_o,
  output logic               run_last_o,
  output logic               clamped_o
);
  import prs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SQ, S_SUM, S_CNT, S_DIV, S_PTS, S_VTX
  } state_e;

  state_e             state_q;
  prs_cmd_t           cmd_q;
  logic               wrap_q;
  logic signed [15:0] x0_q, y0_q;
  logic signed [16:0] dx_q, dy_q;
  logic [33:0]        sqx_q, sqy_q, d2_q;
  logic [NsW-1:0]     ns_q;
  logic [CntW-1:0]    n_q, j_q, remx_q, remy_q;
  logic               cl_q, vcl_q, sgx_q, sgy_q;
  logic [15:0]        ax_q, ay_q, bigqx_q, bigqy_q, qx_q, qy_q;
  logic [CntW:0]      bigrx_q, bigry_q, rx_q, ry_q;
  logic [3:0]         bit_q;
  logic               ovalid_q;

  // load of a segment: from the incoming word or the held one
  prs_cmd_t           lsrc;
  logic               lwrap;
  logic signed [15:0] ld_x0, ld_y0, ld_x1, ld_y1;
  logic signed [16:0] ld_dx, ld_dy;
  logic signed [33:0] mx, my;
  logic [2*NsW-1:0]   sq;
  logic               too_long;
  logic [16:0]        absx, absy;
  logic [CntW:0]      tmpx, tmpy, two_n;
  logic               gex, gey;
  logic [CntW-1:0]    remx_n, remy_n;
  logic [CntW+1:0]    rsx, rsy;
  logic               wx, wy;
  logic [15:0]        qx_n, qy_n;
  logic [CntW:0]      rx_n, ry_n;
  logic [16:0]        px_s, py_s;
  logic               can_emit, pts_end, wrap_more;

  assign lsrc  = (state_q == S_IDLE) ? cmd_i : cmd_q;
  assign lwrap = (state_q == S_IDLE) ? !cmd_i.do_seg : 1'b1;
  assign ld_x0 = lwrap ? lsrc.x : lsrc.px;
  assign ld_y0 = lwrap ? lsrc.y : lsrc.py;
  assign ld_x1 = lwrap ? lsrc.sx : lsrc.x;
  assign ld_y1 = lwrap ? lsrc.sy : lsrc.y;
  assign ld_dx = {ld_x1[15], ld_x1} - {ld_x0[15], ld_x0};
  assign ld_dy = {ld_y1[15], ld_y1} - {ld_y0[15], ld_y0};

  assign mx       = dx_q * dx_q;
  assign my       = dy_q * dy_q;
  assign sq       = ns_q * ns_q;
  assign too_long = sq < (2*NsW)'(d2_q);

  assign absx = dx_q[16] ? 17'(-dx_q) : 17'(dx_q);
  assign absy = dy_q[16] ? 17'(-dy_q) : 17'(dy_q);

  // one restoring divide step per cycle on both axes
  assign tmpx   = {remx_q, ax_q[15]};
  assign tmpy   = {remy_q, ay_q[15]};
  assign gex    = tmpx >= {1'b0, n_q};
  assign gey    = tmpy >= {1'b0, n_q};
  assign remx_n = gex ? CntW'(tmpx - {1'b0, n_q}) : CntW'(tmpx);
  assign remy_n = gey ? CntW'(tmpy - {1'b0, n_q}) : CntW'(tmpy);

  // stepping of the rounded quotient from one point to the next
  assign two_n = {n_q, 1'b0};
  assign rsx   = {1'b0, rx_q} + {1'b0, bigrx_q};
  assign rsy   = {1'b0, ry_q} + {1'b0, bigry_q};
  assign wx    = rsx >= {1'b0, two_n};
  assign wy    = rsy >= {1'b0, two_n};
  assign qx_n  = qx_q + bigqx_q + 16'(wx);
  assign qy_n  = qy_q + bigqy_q + 16'(wy);
  assign rx_n  = wx ? (CntW+1)'(rsx - {1'b0, two_n}) : (CntW+1)'(rsx);
  assign ry_n  = wy ? (CntW+1)'(rsy - {1'b0, two_n}) : (CntW+1)'(rsy);
  assign px_s  = {x0_q[15], x0_q} + (sgx_q ? 17'(-{1'b0, qx_n}) : {1'b0, qx_n});
  assign py_s  = {y0_q[15], y0_q} + (sgy_q ? 17'(-{1'b0, qy_n}) : {1'b0, qy_n});

  assign can_emit  = !ovalid_q || out_ready_i;
  assign pts_end   = (j_q == n_q - CntW'(1));
  assign wrap_more = wrap_q && (n_q > CntW'(1));

  assign cmd_ready_o = (state_q == S_IDLE);
  assign out_valid_o = ovalid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
      cmd_q    <= '0;
      wrap_q   <= 1'b0;
      x0_q     <= '0;
      y0_q     <= '0;
      dx_q     <= '0;
      dy_q     <= '0;
      sqx_q    <= '0;
      sqy_q    <= '0;
      d2_q     <= '0;
      ns_q     <= '0;
      n_q      <= '0;
      j_q      <= '0;
      cl_q     <= 1'b0;
      vcl_q    <= 1'b0;
      sgx_q    <= 1'b0;
      sgy_q    <= 1'b0;
      ax_q     <= '0;
      ay_q     <= '0;
      remx_q   <= '0;
      remy_q   <= '0;
      bit_q    <= '0;
      bigqx_q  <= '0;
      bigqy_q  <= '0;
      bigrx_q  <= '0;
      bigry_q  <= '0;
      qx_q     <= '0;
      qy_q     <= '0;
      rx_q     <= '0;
      ry_q     <= '0;
      out_x_o    <= '0;
      out_y_o    <= '0;
      path_end_o <= 1'b0;
      run_last_o <= 1'b0;
      clamped_o  <= 1'b0;
    end else begin
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q  <= cmd_i;
            vcl_q  <= 1'b0;
            x0_q   <= ld_x0;
            y0_q   <= ld_y0;
            dx_q   <= ld_dx;
            dy_q   <= ld_dy;
            wrap_q <= lwrap && cmd_i.do_wrap;
            if (cmd_i.do_seg || cmd_i.do_wrap) state_q <= S_SQ;
            else state_q <= S_VTX;
          end
        end
        S_SQ: begin
          sqx_q   <= 34'(mx);
          sqy_q   <= 34'(my);
          state_q <= S_SUM;
        end
        S_SUM: begin
          d2_q    <= sqx_q + sqy_q;
          ns_q    <= NsW'(spacing_i);
          n_q     <= CntW'(1);
          state_q <= S_CNT;
        end
        S_CNT: begin
          if ((n_q < CntW'(MaxSegments)) && too_long) begin
            n_q  <= n_q + CntW'(1);
            ns_q <= ns_q + NsW'(spacing_i);
          end else begin
            cl_q <= too_long;
            if (!wrap_q) vcl_q <= too_long;
            ax_q   <= absx[15:0];
            ay_q   <= absy[15:0];
            sgx_q  <= dx_q[16];
            sgy_q  <= dy_q[16];
            remx_q <= '0;
            remy_q <= '0;
            bit_q  <= '0;
            if (wrap_q) begin
              state_q <= S_VTX;
            end else if (n_q > CntW'(1)) begin
              state_q <= S_DIV;
            end else if (cmd_q.do_wrap) begin
              x0_q    <= ld_x0;
              y0_q    <= ld_y0;
              dx_q    <= ld_dx;
              dy_q    <= ld_dy;
              wrap_q  <= 1'b1;
              state_q <= S_SQ;
            end else begin
              state_q <= S_VTX;
            end
          end
        end
        S_DIV: begin
          ax_q   <= {ax_q[14:0], gex};
          ay_q   <= {ay_q[14:0], gey};
          remx_q <= remx_n;
          remy_q <= remy_n;
          bit_q  <= bit_q + 4'd1;
          if (bit_q == 4'd15) begin
            bigqx_q <= {ax_q[14:0], gex};
            bigqy_q <= {ay_q[14:0], gey};
            bigrx_q <= {remx_n, 1'b0};
            bigry_q <= {remy_n, 1'b0};
            qx_q    <= '0;
            qy_q    <= '0;
            rx_q    <= {1'b0, n_q};
            ry_q    <= {1'b0, n_q};
            j_q     <= CntW'(1);
            state_q <= S_PTS;
          end
        end
        S_PTS: begin
          if (can_emit) begin
            ovalid_q   <= 1'b1;
            out_x_o    <= px_s[15:0];
            out_y_o    <= py_s[15:0];
            clamped_o  <= cl_q;
            run_last_o <= wrap_q && pts_end;
            path_end_o <= wrap_q && pts_end && cmd_q.last;
            qx_q <= qx_n;
            qy_q <= qy_n;
            rx_q <= rx_n;
            ry_q <= ry_n;
            j_q  <= j_q + CntW'(1);
            if (pts_end) begin
              if (wrap_q) begin
                state_q <= S_IDLE;
              end else if (cmd_q.do_wrap) begin
                x0_q    <= ld_x0;
                y0_q    <= ld_y0;
                dx_q    <= ld_dx;
                dy_q    <= ld_dy;
                wrap_q  <= 1'b1;
                state_q <= S_SQ;
              end else begin
                state_q <= S_VTX;
              end
            end
          end
        end
        S_VTX: begin
          if (can_emit) begin
            ovalid_q   <= 1'b1;
            out_x_o    <= cmd_q.x;
            out_y_o    <= cmd_q.y;
            clamped_o  <= vcl_q;
            run_last_o <= !wrap_more;
            path_end_o <= !wrap_more && cmd_q.last;
            if (wrap_more) state_q <= S_DIV;
            else state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/polyline_resampler_top.sv
// channel    dir  tdata              tuser                    tlast
// s_axis     in   point_x, point_y   path_first, path_closed  path_last
// m_axis     out  out_x, out_y       run_last, clamped        path_end
// cfg        in   spacing            -                        -
// a plain vertex is emitted directly; a subdivided segment with n parts goes through
// squaring, summing, the count search, a 16-bit divide and stepping of n - 1 points
// a closed path adds the same steps again for the wrap segment
// the back end divider and count search set the rate; the queue holds two vertices
// reset clears path state and spacing; either side may stall at any time
module polyline_resampler_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // point_x, point_y
  input  logic [1:0]  s_axis_tuser_i,  // path_first, path_closed
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // out_x, out_y
  output logic [1:0]  m_axis_tuser_o,  // run_last, clamped
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);
  import prs_pkg::*;

  logic [15:0]        spacing_q;
  logic               fq_valid, fq_ready, qb_valid, qb_ready;
  prs_cmd_t           fq_cmd, qb_cmd;
  logic signed [15:0] ox, oy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spacing_q <= '0;
    end else if (cfg_valid_i) begin
      spacing_q <= cfg_data_i;
    end
  end

  prs_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .point_x_i     (s_axis_tdata_i[15:0]),
    .point_y_i     (s_axis_tdata_i[31:16]),
    .path_first_i  (s_axis_tuser_i[0]),
    .path_last_i   (s_axis_tlast_i),
    .path_closed_i (s_axis_tuser_i[1]),
    .spacing_i     (spacing_q),
    .cmd_valid_o   (fq_valid),
    .cmd_ready_i   (fq_ready),
    .cmd_o         (fq_cmd)
  );

  prs_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_ready_o (fq_ready),
    .wr_data_i  (fq_cmd),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_data_o  (qb_cmd)
  );

  prs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (qb_valid),
    .cmd_ready_o (qb_ready),
    .cmd_i       (qb_cmd),
    .spacing_i   (spacing_q),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_x_o     (ox),
    .out_y_o     (oy),
    .path_end_o  (m_axis_tlast_o),
    .run_last_o  (m_axis_tuser_o[0]),
    .clamped_o   (m_axis_tuser_o[1])
  );

  assign m_axis_tdata_o = {oy, ox};

endmodule

FILE: sim/tb_polyline_resampler_top.sv
// testbench for polyline_resampler_top: random and directed vertex streams
// checked against an in-bench model of segment subdivision; needs prs_pkg and the top
module tb_polyline_resampler_top;
  import prs_pkg::*;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               first;
    logic               last;
    logic               closed;
  } vertex_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               path_end;
    logic               run_last;
    logic               clamped;
  } point_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic [1:0] s_axis_tuser_i = '0;
  logic s_axis_tlast_i = 1'b0;
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [1:0] m_axis_tuser_o;
  logic m_axis_tlast_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  polyline_resampler_top dut (.*);

  always #6 clk_i = ~clk_i;

  vertex_t pending_vertices[$];
  point_t expected_points[$];
  int unsigned idle_pct = 34;
  int unsigned cycle_count = 0;
  int errors = 0;
  logic [15:0] spacing_reg = '0;
  int prev_x = 0, prev_y = 0, start_x = 0, start_y = 0;
  bit in_path = 0;

  function automatic int round_scaled(int d, int j, int n);
    longint num, mag, q;
    num = longint'(d) * j;
    mag = num < 0 ? -num : num;
    q = (2 * mag + n) / (2 * n);
    return num < 0 ? -int'(q) : int'(q);
  endfunction

  task automatic push_point(int x, int y, bit cl);
    point_t p;
    p.x = x[15:0];
    p.y = y[15:0];
    p.path_end = 0;
    p.run_last = 0;
    p.clamped = cl;
    expected_points = {expected_points, p};
  endtask

  task automatic queue_vertex(vertex_t v);
    pending_vertices = {pending_vertices, v};
  endtask

  task automatic subdivide(int x0, int y0, int x1, int y1, output bit cl);
    longint d2, s;
    int dx, dy, n;
    dx = x1 - x0;
    dy = y1 - y0;
    d2 = longint'(dx) * dx + longint'(dy) * dy;
    s = spacing_reg;
    n = 1;
    while (n < MaxSegments && (n * s) * (n * s) < d2) n++;
    cl = (n * s) * (n * s) < d2;
    for (int j = 1; j < n; j++)
      push_point(x0 + round_scaled(dx, j, n), y0 + round_scaled(dy, j, n), cl);
  endtask

  task automatic predict_vertex(vertex_t v);
    int x, y;
    bit cl, wcl;
    point_t p;
    x = v.x;
    y = v.y;
    cl = 0;
    if (v.first || !in_path) begin
      start_x = x;
      start_y = y;
      push_point(x, y, 0);
    end else if (spacing_reg == 0) begin
      push_point(x, y, 0);
    end else begin
      subdivide(prev_x, prev_y, x, y, cl);
      push_point(x, y, cl);
    end
    if (v.last && v.closed && spacing_reg != 0) subdivide(x, y, start_x, start_y, wcl);
    p = expected_points.pop_back();
    p.path_end = v.last;
    p.run_last = 1;
    expected_points = {expected_points, p};
    prev_x = x;
    prev_y = y;
    in_path = !v.last;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      predict_vertex(pending_vertices.pop_front());
    end
    if ((!s_axis_tvalid_i || s_axis_tready_o)) begin
      if (pending_vertices.size() > 0 && $urandom_range(99) >= idle_pct && rst_ni) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i <= {pending_vertices[0].y, pending_vertices[0].x};
        s_axis_tuser_i <= {pending_vertices[0].closed, pending_vertices[0].first};
        s_axis_tlast_i <= pending_vertices[0].last;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    point_t e;
    cycle_count <= cycle_count + 1;
    if (rst_ni) m_axis_tready_i <= $urandom_range(99) >= idle_pct;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_points.size() == 0) begin
        $error("unexpected word x=%0d", $signed(m_axis_tdata_o[15:0]));
        errors++;
      end else begin
        e = expected_points.pop_front();
        if (m_axis_tdata_o[15:0] !== e.x) begin
          $error("out_x exp %0d got %0d", e.x, $signed(m_axis_tdata_o[15:0])); errors++;
        end
        if (m_axis_tdata_o[31:16] !== e.y) begin
          $error("out_y exp %0d got %0d", e.y, $signed(m_axis_tdata_o[31:16])); errors++;
        end
        if (m_axis_tlast_o !== e.path_end) begin
          $error("path_end exp %0b got %0b", e.path_end, m_axis_tlast_o); errors++;
        end
        if (m_axis_tuser_o[0] !== e.run_last) begin
          $error("run_last exp %0b got %0b", e.run_last, m_axis_tuser_o[0]); errors++;
        end
        if (m_axis_tuser_o[1] !== e.clamped) begin
          $error("clamped exp %0b got %0b", e.clamped, m_axis_tuser_o[1]); errors++;
        end
      end
    end
  end

  task automatic write_spacing(logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    spacing_reg = val;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_vertices.size() != 0 || s_axis_tvalid_i || expected_points.size() != 0)
      @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic vertex_t make_vertex(int x, int y, bit f, bit l, bit c);
    vertex_t v;
    v.x = x[15:0];
    v.y = y[15:0];
    v.first = f;
    v.last = l;
    v.closed = c;
    return v;
  endfunction

  function automatic int rand_coord(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  task automatic random_paths(int count, int span);
    int len, made;
    made = 0;
    while (made < count) begin
      if ($urandom_range(9) == 0) begin
        // noise: random flags
        queue_vertex(make_vertex(rand_coord(32767), rand_coord(32767),
          $urandom_range(1), $urandom_range(1), $urandom_range(1)));
        made++;
      end else begin
        len = $urandom_range(6, 1);
        for (int i = 0; i < len; i++)
          queue_vertex(make_vertex(rand_coord(span), rand_coord(span),
            i == 0, i == len - 1, $urandom_range(1)));
        made += len;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // pass through with default spacing, extremes
    queue_vertex(make_vertex(-32768, 32767, 1, 0, 0));
    queue_vertex(make_vertex(32767, -32768, 0, 1, 1));
    drain();
    write_spacing(16'd16);
    // single point closed path, vertex without open path, closed ignored without last
    queue_vertex(make_vertex(100, -100, 1, 1, 1));
    queue_vertex(make_vertex(0, 0, 0, 0, 1));
    queue_vertex(make_vertex(50, 37, 0, 0, 0));
    queue_vertex(make_vertex(-45, 90, 0, 1, 1));
    // saturated segment and wrap, both extremes
    queue_vertex(make_vertex(-32768, -32768, 1, 0, 0));
    queue_vertex(make_vertex(32767, 32767, 0, 0, 0));
    queue_vertex(make_vertex(-32768, 32767, 1, 0, 0));
    queue_vertex(make_vertex(32767, -32768, 0, 1, 1));
    queue_vertex(make_vertex(7, -7, 0, 1, 0));
    drain();
    write_spacing(16'd1);
    queue_vertex(make_vertex(0, 0, 1, 0, 0));
    queue_vertex(make_vertex(3, -5, 0, 0, 0));
    queue_vertex(make_vertex(-9, 2, 0, 1, 1));
    drain();
    write_spacing(16'hFFFF);
    queue_vertex(make_vertex(-32768, 0, 1, 0, 0));
    queue_vertex(make_vertex(32767, 0, 0, 1, 1));
    drain();
    write_spacing(16'd64);
    idle_pct = 0;
    random_paths(120, 1200);
    drain();
    idle_pct = 34;
    random_paths(130, 800);
    drain();
    write_spacing(16'd0);
    random_paths(60, 32767);
    drain();
    write_spacing(16'($urandom_range(16'hFFFF, 1)));
    random_paths(80, 32767);
    drain();
    write_spacing(16'($urandom_range(400, 8)));
    random_paths(90, 4000);
    drain();
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk_i) begin
    if (cycle_count == 2000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end
endmodule

FILE: polyline_resampler_top.f
design/prs_pkg.sv
design/prs_front.sv
design/prs_queue.sv
design/prs_back.sv
design/polyline_resampler_top.sv
sim/tb_polyline_resampler_top.sv
